/* rtl/ssl_pkg.sv */
// Shared types, widths, codes and reset values for the servo slew limiter bank.
package ssl_pkg;

   localparam int ANGLE_W    = 12;
   localparam int SPAN_W     = 11;
   localparam int PULSE_W    = 12;
   localparam int CH_FIELD_W = 4;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam int PROD_W     = PULSE_W + SPAN_W;
   localparam int MULB_W     = ANGLE_W + PULSE_W + 1;
   localparam int NUM_W      = MULB_W + 1;
   localparam int DIVIDEND_W = PROD_W;

   localparam int CHANNELS_DFLT = 16;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic [SPAN_W-1:0]         span_type;
   typedef logic [PULSE_W-1:0]        pulse_type;
   typedef logic [CH_FIELD_W-1:0]     chan_field_type;

   typedef enum logic [OP_W-1:0] {
      OP_SET    = 2'd0,
      OP_TICK   = 2'd1,
      OP_CENTER = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_ANGLE    = 3'd0,
      CSR_MAX_ANGLE    = 3'd1,
      CSR_STEP_SIZE    = 3'd2,
      CSR_CENTER_PULSE = 3'd3,
      CSR_MIN_PULSE    = 3'd4
   } csr_idx_type;

   localparam angle_type MIN_ANGLE_RST    = -12'sd720;
   localparam span_type  MAX_ANGLE_RST    = 11'd720;
   localparam span_type  STEP_SIZE_RST    = 11'd16;
   localparam pulse_type CENTER_PULSE_RST = 12'd1500;
   localparam pulse_type MIN_PULSE_RST    = 12'd1000;

   typedef struct packed {
      op_type         opcode;
      chan_field_type channel;
      angle_type      angle_in;
   } req_type;

   typedef struct packed {
      chan_field_type channel_out;
      angle_type      angle_now;
      pulse_type      pulse_us;
      logic           last;
   } rsp_type;

   typedef struct packed {
      logic      clear_all;
      logic      tgt_we;
      logic      cur_we;
      angle_type tgt;
      angle_type cur;
   } chan_wr_type;

   typedef struct packed {
      angle_type target;
      angle_type current;
   } chan_rd_type;

endpackage

/* rtl/ssl_chan_store.sv */
// Per-channel target and current angle store with valid bits for reset and center.
module ssl_chan_store #(
   parameter int CHANNELS = ssl_pkg::CHANNELS_DFLT,
   parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  ssl_pkg::chan_wr_type wr,
   input  logic [CH_W-1:0]     wr_addr,
   input  logic [CH_W-1:0]     rd_addr,
   output ssl_pkg::chan_rd_type rd
);

   ssl_pkg::angle_type   tgt_mem [CHANNELS];
   ssl_pkg::angle_type   cur_mem [CHANNELS];
   logic [CHANNELS-1:0]  tgt_vld_ff;
   logic [CHANNELS-1:0]  cur_vld_ff;
   ssl_pkg::chan_rd_type rd_ff;

   // invalid entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_vld_ff <= '0;
         cur_vld_ff <= '0;
      end else if (wr.clear_all) begin
         tgt_vld_ff <= '0;
         cur_vld_ff <= '0;
      end else begin
         if (wr.tgt_we) begin
            tgt_vld_ff[wr_addr] <= 1'b1;
         end
         if (wr.cur_we) begin
            cur_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.tgt_we) begin
         tgt_mem[wr_addr] <= wr.tgt;
      end
      if (wr.cur_we) begin
         cur_mem[wr_addr] <= wr.cur;
      end
      rd_ff.target  <= tgt_vld_ff[rd_addr] ? tgt_mem[rd_addr] : '0;
      rd_ff.current <= cur_vld_ff[rd_addr] ? cur_mem[rd_addr] : '0;
   end

   assign rd = rd_ff;

endmodule

/* rtl/ssl_div.sv */
// Restoring divider, one quotient bit per cycle, for quotients known to fit PULSE_W bits.
module ssl_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [ssl_pkg::DIVIDEND_W-1:0]     dividend,
   input  ssl_pkg::span_type                  divisor,
   output logic                               done,
   output ssl_pkg::pulse_type                 quotient
);

   localparam int CNT_W = $clog2(ssl_pkg::PULSE_W);

   ssl_pkg::span_type             rem_ff, rem_in;
   ssl_pkg::pulse_type            quo_ff, quo_in;
   ssl_pkg::span_type             dvs_ff, dvs_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [ssl_pkg::SPAN_W:0]      trial;
   logic [ssl_pkg::SPAN_W:0]      diff;
   logic                          fits;

   assign trial = {rem_ff, quo_ff[ssl_pkg::PULSE_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         // high part is already below the divisor
         rem_in = dividend[ssl_pkg::DIVIDEND_W-1:ssl_pkg::PULSE_W];
         quo_in = dividend[ssl_pkg::PULSE_W-1:0];
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? diff[ssl_pkg::SPAN_W-1:0] : trial[ssl_pkg::SPAN_W-1:0];
         quo_in = {quo_ff[ssl_pkg::PULSE_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ssl_pkg::PULSE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/servo_slew_limiter_bank.sv */
// Top level of the servo slew limiter bank: command port, config registers, sequencer.
//
// A bank of CHANNELS servo channels, each holding a target angle, a current angle and
// a pending flag, with angles in signed 1/16 degree. A transaction is taken when start
// is high and busy is low. Set target (clamped to min_angle..max_angle) and center all
// finish in the cycle they are taken and never raise busy. A read raises busy and
// gives one result. A tick walks the channels in ascending order, skipping channels that
// are not pending; a pending one passes through the scan, fetch and slew, two multiply
// steps, a range check, the restoring divider that yields one pulse bit per cycle, and the
// output state; channels whose pulse saturates or whose full scale is zero skip the divider.
// Results appear with rsp_valid high for exactly one cycle and must be taken then:
// there is no back-pressure. The final result of a tick or read carries last. A tick with
// nothing pending gives no result. Write configuration only while busy is low; csr_ready
// is always high and writes to an unknown index are dropped.
module servo_slew_limiter_bank #(
   parameter int CHANNELS = ssl_pkg::CHANNELS_DFLT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  ssl_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output ssl_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ssl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssl_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PAD_W = ssl_pkg::NUM_W - ssl_pkg::SPAN_W - ssl_pkg::PULSE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_MUL0,
      ST_MUL1,
      ST_PREP,
      ST_DIV,
      ST_NEXT
   } state_type;

   // configuration registers
   ssl_pkg::angle_type cfg_min_angle_ff;
   ssl_pkg::span_type  cfg_max_angle_ff;
   ssl_pkg::span_type  cfg_step_ff;
   ssl_pkg::pulse_type cfg_center_ff;
   ssl_pkg::pulse_type cfg_min_pulse_ff;

   // sequencer state
   state_type                       state_ff, state_in;
   logic [CH_W-1:0]                 idx_ff, idx_in;
   logic                            op_read_ff, op_read_in;
   logic                            oor_ff, oor_in;
   logic                            last_ff, last_in;
   ssl_pkg::chan_field_type         ch_ff, ch_in;
   ssl_pkg::angle_type              angle_ff, angle_in;
   logic [ssl_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [ssl_pkg::NUM_W-1:0]       num_ff, num_in;
   logic [CHANNELS-1:0]             pending_ff, pending_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   ssl_pkg::rsp_type                rsp_ff, rsp_in;

   // datapath helpers
   ssl_pkg::chan_wr_type            wr;
   logic [CH_W-1:0]                 rd_addr;
   logic [CH_W-1:0]                 req_idx;
   ssl_pkg::chan_rd_type            rd;
   logic                            req_in_range;
   ssl_pkg::angle_type              clamped;
   logic signed [ssl_pkg::ANGLE_W:0] diff;
   logic [ssl_pkg::ANGLE_W:0]       mag;
   logic                            arrive;
   logic [ssl_pkg::ANGLE_W:0]       stepped;
   ssl_pkg::angle_type              moved;
   logic [CHANNELS-1:0]             above_mask;
   logic                            higher_pending;
   logic signed [ssl_pkg::PULSE_W:0] pulse_delta;
   logic signed [ssl_pkg::MULB_W-1:0] prod_b;
   logic [ssl_pkg::NUM_W-1:0]       sat_limit;
   logic                            div_start;
   logic                            div_done;
   ssl_pkg::pulse_type              div_quo;
   logic                            last_chan;

   // configuration writes; unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_min_angle_ff <= ssl_pkg::MIN_ANGLE_RST;
         cfg_max_angle_ff <= ssl_pkg::MAX_ANGLE_RST;
         cfg_step_ff      <= ssl_pkg::STEP_SIZE_RST;
         cfg_center_ff    <= ssl_pkg::CENTER_PULSE_RST;
         cfg_min_pulse_ff <= ssl_pkg::MIN_PULSE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            ssl_pkg::CSR_MIN_ANGLE:    cfg_min_angle_ff <= csr_data;
            ssl_pkg::CSR_MAX_ANGLE:    cfg_max_angle_ff <= csr_data[ssl_pkg::SPAN_W-1:0];
            ssl_pkg::CSR_STEP_SIZE:    cfg_step_ff      <= csr_data[ssl_pkg::SPAN_W-1:0];
            ssl_pkg::CSR_CENTER_PULSE: cfg_center_ff    <= csr_data;
            ssl_pkg::CSR_MIN_PULSE:    cfg_min_pulse_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // request decode
   assign req_in_range = {1'b0, req_data.channel} < (ssl_pkg::CH_FIELD_W + 1)'(CHANNELS);
   assign req_idx      = req_data.channel[CH_W-1:0];

   // lower bound is checked first; when the limits cross, inputs below it get min_angle, the rest get max_angle
   always_comb begin
      if (req_data.angle_in < cfg_min_angle_ff) begin
         clamped = cfg_min_angle_ff;
      end else if (req_data.angle_in > $signed({1'b0, cfg_max_angle_ff})) begin
         clamped = $signed({1'b0, cfg_max_angle_ff});
      end else begin
         clamped = req_data.angle_in;
      end
   end

   // slew step for the fetched channel
   assign diff    = {rd.target[ssl_pkg::ANGLE_W-1], rd.target}
                  - {rd.current[ssl_pkg::ANGLE_W-1], rd.current};
   assign mag     = diff[ssl_pkg::ANGLE_W] ? -diff : diff;
   assign arrive  = mag <= {2'b00, cfg_step_ff};
   assign stepped = diff[ssl_pkg::ANGLE_W]
                  ? {rd.current[ssl_pkg::ANGLE_W-1], rd.current} - {2'b00, cfg_step_ff}
                  : {rd.current[ssl_pkg::ANGLE_W-1], rd.current} + {2'b00, cfg_step_ff};
   assign moved   = arrive ? rd.target : stepped[ssl_pkg::ANGLE_W-1:0];

   // last of a tick: nothing pending above this channel
   always_comb begin
      for (int j = 0; j < CHANNELS; j++) begin
         above_mask[j] = j > int'(idx_ff);
      end
   end
   assign higher_pending = |(pending_ff & above_mask);

   // pulse numerator: center*max_angle + angle*(center - min_pulse)
   assign pulse_delta = {1'b0, cfg_center_ff} - {1'b0, cfg_min_pulse_ff};
   assign prod_b      = ssl_pkg::MULB_W'(angle_ff) * ssl_pkg::MULB_W'(pulse_delta);
   assign sat_limit   = {PAD_W'(0), cfg_max_angle_ff, ssl_pkg::PULSE_W'(0)};

   assign last_chan = idx_ff == CH_W'(CHANNELS - 1);
   assign rd_addr   = (state_ff == ST_IDLE) ? req_idx : idx_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      op_read_in   = op_read_ff;
      oor_in       = oor_ff;
      last_in      = last_ff;
      ch_in        = ch_ff;
      angle_in     = angle_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      pending_in   = pending_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr           = '0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.opcode)
                  ssl_pkg::OP_SET: begin
                     if (req_in_range) begin
                        wr.tgt_we           = 1'b1;
                        wr.tgt              = clamped;
                        pending_in[req_idx] = 1'b1;
                     end
                  end
                  ssl_pkg::OP_TICK: begin
                     idx_in     = '0;
                     op_read_in = 1'b0;
                     state_in   = ST_SCAN;
                  end
                  ssl_pkg::OP_CENTER: begin
                     wr.clear_all = 1'b1;
                     pending_in   = '1;
                  end
                  ssl_pkg::OP_READ: begin
                     op_read_in = 1'b1;
                     oor_in     = !req_in_range;
                     ch_in      = req_data.channel;
                     last_in    = 1'b1;
                     state_in   = ST_FETCH;
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            // skip idle channels, one per cycle
            if (pending_ff[idx_ff]) begin
               state_in = ST_FETCH;
            end else if (last_chan) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + CH_W'(1);
            end
         end

         ST_FETCH: begin
            if (op_read_ff) begin
               angle_in = oor_ff ? '0 : rd.current;
            end else begin
               wr.cur_we  = 1'b1;
               wr.cur     = moved;
               angle_in   = moved;
               ch_in      = ssl_pkg::CH_FIELD_W'(idx_ff);
               last_in    = !higher_pending;
               if (arrive) begin
                  pending_in[idx_ff] = 1'b0;
               end
            end
            state_in = ST_MUL0;
         end

         ST_MUL0: begin
            prod_in  = ssl_pkg::PROD_W'(cfg_center_ff) * ssl_pkg::PROD_W'(cfg_max_angle_ff);
            state_in = ST_MUL1;
         end

         ST_MUL1: begin
            num_in   = {PAD_W'(0), prod_ff} + {prod_b[ssl_pkg::MULB_W-1], prod_b};
            state_in = ST_PREP;
         end

         ST_PREP: begin
            rsp_in.channel_out = ch_ff;
            rsp_in.angle_now   = angle_ff;
            rsp_in.last        = last_ff;
            if (cfg_max_angle_ff == '0) begin
               rsp_in.pulse_us = cfg_center_ff;
               rsp_valid_in    = 1'b1;
               state_in        = ST_NEXT;
            end else if (num_ff[ssl_pkg::NUM_W-1]) begin
               rsp_in.pulse_us = '0;
               rsp_valid_in    = 1'b1;
               state_in        = ST_NEXT;
            end else if (num_ff >= sat_limit) begin
               rsp_in.pulse_us = '1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_NEXT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end

         ST_DIV: begin
            if (div_done) begin
               rsp_in.pulse_us = div_quo;
               rsp_valid_in    = 1'b1;
               state_in        = ST_NEXT;
            end
         end

         ST_NEXT: begin
            if (op_read_ff || last_chan) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + CH_W'(1);
               state_in = ST_SCAN;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         op_read_ff   <= 1'b0;
         oor_ff       <= 1'b0;
         last_ff      <= 1'b0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         op_read_ff   <= op_read_in;
         oor_ff       <= oor_in;
         last_ff      <= last_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff    <= ch_in;
      angle_ff <= angle_in;
      prod_ff  <= prod_in;
      num_ff   <= num_in;
      rsp_ff   <= rsp_in;
   end

   ssl_chan_store #(
      .CHANNELS (CHANNELS),
      .CH_W     (CH_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .wr_addr (state_ff == ST_IDLE ? req_idx : idx_ff),
      .rd_addr (rd_addr),
      .rd      (rd)
   );

   ssl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff[ssl_pkg::DIVIDEND_W-1:0]),
      .divisor  (cfg_max_angle_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // results never come back to back
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   // a result only leaves while a tick or read is in progress
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result while idle");

   // tick and read take the sequencer out of idle
   a_busy_after_walk: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.opcode == ssl_pkg::OP_TICK
                          || req_data.opcode == ssl_pkg::OP_READ)) |=> busy)
      else $error("tick or read did not start");

   // the divider finishes only while the sequencer waits for it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider done outside wait state");
`endif

endmodule
